// ===== src/awp_pkg.sv =====
// ----------------------------------------------------------------------------
// awp_pkg: shared types and constants
// Types and codes shared by the widest-path controller, datapath and top.
// ----------------------------------------------------------------------------
package awp_pkg;

  localparam int VERT_W  = 6;
  localparam int WIDTH_W = 30;

  typedef logic [WIDTH_W-1:0] width_t;
  typedef logic [VERT_W-1:0]  vert_t;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_COPY   = 2'd2;
  localparam logic [1:0] MODE_UPDATE = 2'd3;

  localparam width_t SAME_VERTEX = 30'h3FFFFFFF;
  localparam width_t MAX_WEIGHT  = 30'h3FFFFFFE;

  typedef struct packed {
    logic       load;
    logic [1:0] mode;
    logic       query;
  } cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic sweep_done;
    logic pipe_busy;
    logic out_valid;
  } sts_t;

endpackage

// ===== src/all_pairs_widest_path_top.sv =====
// A query is issued from S_QUERY once the result register is free; the answer is then
// read from the matrix memory and registered. A clear writes the VERTICES*VERTICES entries,
// one matrix entry per cycle through the write port. An add edge copies both endpoint rows,
// then runs the update pass through the matrix memory and drains the update pipeline.
// Reset runs the clear pass; no request is taken meanwhile.
// ----------------------------------------------------------------------------
// all_pairs_widest_path_top: all-pairs widest-path matrix
// Keeps widest-path values of an undirected graph and answers pair queries.
// ----------------------------------------------------------------------------
module all_pairs_widest_path_top #(
  parameter int VERTICES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // op[1:0], vertex_a[7:2], vertex_b[13:8], weight[43:14]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // width[29:0]
);
  import awp_pkg::*;

  cmd_t   cmd;
  sts_t   sts;
  width_t out_width;

  awp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .op(s_axis_tdata[1:0]),
    .sts(sts), .in_ready(s_axis_tready), .cmd(cmd)
  );

  awp_dp #(.VERTICES(VERTICES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .vertex_a(s_axis_tdata[7:2]), .vertex_b(s_axis_tdata[13:8]),
    .weight(s_axis_tdata[43:14]), .out_ready(m_axis_tready),
    .sts(sts), .out_valid(m_axis_tvalid), .out_width(out_width)
  );

  assign m_axis_tdata = {2'b00, out_width};

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.mode != MODE_NONE) |-> !s_axis_tready)
    else $error("request accepted during a sweep");

  a_query_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.query |-> !m_axis_tvalid)
    else $error("query issued while a result is pending");

  a_query_result: assert property (@(posedge clk) disable iff (rst)
    cmd.query |=> ##1 m_axis_tvalid)
    else $error("query result missing");

endmodule

// ===== src/awp_ram.sv =====
// ----------------------------------------------------------------------------
// awp_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module awp_ram #(
  parameter int DATA_W = 30,
  parameter int DEPTH  = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/awp_ctrl.sv =====
// ----------------------------------------------------------------------------
// awp_ctrl: widest-path sequencer
// Accepts requests, steps the datapath through clear, copy and update, and issues queries.
// ----------------------------------------------------------------------------
module awp_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [1:0]    op,
  input  awp_pkg::sts_t sts,
  output logic          in_ready,
  output awp_pkg::cmd_t cmd
);
  import awp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_COPY   = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_QUERY  = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (op)
            OP_CLEAR: state_next = S_CLEAR;
            OP_ADD: begin
              if (sts.edge_ok) state_next = S_COPY;
            end
            OP_QUERY: state_next = S_QUERY;
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.mode = MODE_CLEAR;
        if (sts.sweep_done) state_next = S_IDLE;
      end
      S_COPY: begin
        cmd.mode = MODE_COPY;
        if (sts.sweep_done) state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.mode = MODE_UPDATE;
        if (sts.sweep_done) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) state_next = S_IDLE;
      end
      S_QUERY: begin
        if (!sts.out_valid) begin
          cmd.query  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== src/awp_dp.sv =====
// ----------------------------------------------------------------------------
// awp_dp: widest-path datapath
// Matrix memory, endpoint row copies, update pipeline and result register.
// ----------------------------------------------------------------------------
module awp_dp #(
  parameter int VERTICES = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  awp_pkg::cmd_t   cmd,
  input  awp_pkg::vert_t  vertex_a,
  input  awp_pkg::vert_t  vertex_b,
  input  awp_pkg::width_t weight,
  input  logic            out_ready,
  output awp_pkg::sts_t   sts,
  output logic            out_valid,
  output awp_pkg::width_t out_width
);
  import awp_pkg::*;

  localparam int VW = $clog2(VERTICES);
  localparam int AW = 2 * VW;
  localparam logic [VW-1:0] LAST = VW'(VERTICES - 1);

  function automatic width_t min3(input width_t x, input width_t y, input width_t z);
    width_t m;
    m = (x < y) ? x : y;
    return (m < z) ? m : z;
  endfunction

  logic [8:0] a_ext, b_ext;
  logic       a_in, b_in;

  logic [VW-1:0] ra, rb;
  width_t        rw;
  logic          rq_ok;

  logic [VW-1:0] ci, cj;
  logic          sweep_done;

  logic          m_we;
  logic [AW-1:0] m_waddr, m_raddr;
  width_t        m_wdata, m_rdata;
  width_t        aj_q, ai_q, bj_q, bi_q;

  logic          cp_valid, cp_sel;
  logic [VW-1:0] cp_j;
  logic          up_valid;
  logic [AW-1:0] up_addr;
  logic          qv;

  logic          s2_valid;
  logic [AW-1:0] s2_addr;
  width_t        s2_cur, s2_p1, s2_p2, wb_data;

  assign a_ext = 9'(vertex_a);
  assign b_ext = 9'(vertex_b);
  assign a_in  = a_ext < 9'(VERTICES);
  assign b_in  = b_ext < 9'(VERTICES);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ra    <= a_ext[VW-1:0];
      rb    <= b_ext[VW-1:0];
      rw    <= (weight == SAME_VERTEX) ? MAX_WEIGHT : weight;
      rq_ok <= a_in && b_in;
    end
  end

  always_comb begin
    sweep_done = 1'b0;
    case (cmd.mode)
      MODE_CLEAR, MODE_UPDATE: sweep_done = (ci == LAST) && (cj == LAST);
      MODE_COPY:               sweep_done = ci[0] && (cj == LAST);
      default:                 sweep_done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ci <= '0;
      cj <= '0;
    end else if (cmd.mode != MODE_NONE) begin
      if (sweep_done) begin
        ci <= '0;
        cj <= '0;
      end else if (cj == LAST) begin
        cj <= '0;
        ci <= ci + 1'b1;
      end else begin
        cj <= cj + 1'b1;
      end
    end
  end

  always_comb begin
    if (cmd.query) begin
      m_raddr = {ra, rb};
    end else if (cmd.mode == MODE_COPY) begin
      m_raddr = {(ci[0] ? rb : ra), cj};
    end else begin
      m_raddr = {ci, cj};
    end
    if (cmd.mode == MODE_CLEAR) begin
      m_we    = 1'b1;
      m_waddr = {ci, cj};
      m_wdata = (ci == cj) ? SAME_VERTEX : '0;
    end else begin
      m_we    = s2_valid;
      m_waddr = s2_addr;
      m_wdata = wb_data;
    end
  end

  awp_ram #(.DATA_W(WIDTH_W), .DEPTH(2 ** AW)) u_matrix (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );

  awp_ram #(.DATA_W(WIDTH_W), .DEPTH(VERTICES)) u_col_aj (
    .clk(clk), .we(cp_valid && !cp_sel), .waddr(cp_j), .wdata(m_rdata),
    .raddr(cj), .rdata(aj_q)
  );

  awp_ram #(.DATA_W(WIDTH_W), .DEPTH(VERTICES)) u_col_ai (
    .clk(clk), .we(cp_valid && !cp_sel), .waddr(cp_j), .wdata(m_rdata),
    .raddr(ci), .rdata(ai_q)
  );

  awp_ram #(.DATA_W(WIDTH_W), .DEPTH(VERTICES)) u_col_bj (
    .clk(clk), .we(cp_valid && cp_sel), .waddr(cp_j), .wdata(m_rdata),
    .raddr(cj), .rdata(bj_q)
  );

  awp_ram #(.DATA_W(WIDTH_W), .DEPTH(VERTICES)) u_col_bi (
    .clk(clk), .we(cp_valid && cp_sel), .waddr(cp_j), .wdata(m_rdata),
    .raddr(ci), .rdata(bi_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cp_valid <= 1'b0;
      up_valid <= 1'b0;
      qv       <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      cp_valid <= (cmd.mode == MODE_COPY);
      up_valid <= (cmd.mode == MODE_UPDATE);
      qv       <= cmd.query;
      s2_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    cp_sel  <= ci[0];
    cp_j    <= cj;
    up_addr <= {ci, cj};
    s2_addr <= up_addr;
    s2_cur  <= m_rdata;
    s2_p1   <= min3(ai_q, rw, bj_q);
    s2_p2   <= min3(bi_q, rw, aj_q);
  end

  always_comb begin
    wb_data = s2_cur;
    if (s2_p1 > wb_data) wb_data = s2_p1;
    if (s2_p2 > wb_data) wb_data = s2_p2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (qv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (qv) begin
      out_width <= rq_ok ? m_rdata : '0;
    end
  end

  assign sts.edge_ok    = a_in && b_in && (vertex_a != vertex_b);
  assign sts.sweep_done = sweep_done;
  assign sts.pipe_busy  = up_valid || s2_valid;
  assign sts.out_valid  = out_valid;

endmodule

// ===== sim/tb_all_pairs_widest_path_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_all_pairs_widest_path_top: self-checking bench for the widest-path matrix
// Drives clear, add-edge, query and unused-opcode requests with random idling on both sides,
// keeps its own copy of the widest-path matrix and checks every query answer.
// ----------------------------------------------------------------------------
module tb_all_pairs_widest_path_top;
  import awp_pkg::*;

  localparam int NV = 64;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [1:0] op;
    vert_t      va;
    vert_t      vb;
    width_t     wt;
  } req_t;

  typedef struct {
    req_t   r;
    logic   known;
    width_t res;
  } row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  width_t widest [NV][NV];
  width_t width_queue [$];
  int     mismatches;
  int     cycles;
  logic   fill_hold;
  logic   quiet;
  row_t   directed [$];

  all_pairs_widest_path_top #(.VERTICES(NV)) uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic width_t min3(width_t x, width_t y, width_t z);
    width_t m;
    m = (x < y) ? x : y;
    return (m < z) ? m : z;
  endfunction

  function automatic void clear_widest();
    for (int i = 0; i < NV; i++)
      for (int j = 0; j < NV; j++)
        widest[i][j] = (i == j) ? SAME_VERTEX : '0;
  endfunction

  // Merge one edge: every pair takes the best path through it either way.
  function automatic void merge_edge(vert_t a, vert_t b, width_t w);
    width_t ca [NV];
    width_t cb [NV];
    width_t cur;
    width_t p1;
    width_t p2;
    if (a >= NV || b >= NV || a == b) return;
    if (w > MAX_WEIGHT) w = MAX_WEIGHT;
    for (int i = 0; i < NV; i++) begin
      ca[i] = widest[i][a];
      cb[i] = widest[i][b];
    end
    for (int i = 0; i < NV; i++)
      for (int j = 0; j < NV; j++) begin
        cur = widest[i][j];
        p1 = min3(ca[i], w, cb[j]);
        p2 = min3(cb[i], w, ca[j]);
        if (p1 > cur) cur = p1;
        if (p2 > cur) cur = p2;
        widest[i][j] = cur;
      end
  endfunction

  function automatic void predict_widest(req_t r);
    width_t res;
    res = '0;
    case (r.op)
      OP_CLEAR: clear_widest();
      OP_ADD: merge_edge(r.va, r.vb, r.wt);
      OP_QUERY: begin
        if (r.va < NV && r.vb < NV) res = widest[r.va][r.vb];
        width_queue = {width_queue, res};
      end
      default: ;
    endcase
  endfunction

  function automatic req_t mk(logic [1:0] op, int a, int b, width_t w);
    req_t r;
    r.op = op;
    r.va = a[5:0];
    r.vb = b[5:0];
    r.wt = w;
    return r;
  endfunction

  function automatic void add_row(req_t r, logic known, width_t res);
    row_t x;
    x.r = r;
    x.known = known;
    x.res = res;
    directed = {directed, x};
  endfunction

  task automatic send_request(req_t r, logic idle_ok);
    if (idle_ok && !quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, r.wt, r.vb, r.va, r.op};
    do @(posedge clk); while (!s_axis_tready);
    predict_widest(r);
  endtask

  task automatic drain_all();
    s_axis_tvalid <= 1'b0;
    while (width_queue.size() != 0) @(posedge clk);
  endtask

  function automatic req_t random_request(int span);
    req_t r;
    int k;
    k = $urandom_range(0, 99);
    r.va = vert_t'($urandom_range(0, span - 1));
    r.vb = vert_t'($urandom_range(0, span - 1));
    r.wt = width_t'($urandom);
    if ($urandom_range(0, 9) == 0) r.va = vert_t'($urandom);
    if ($urandom_range(0, 9) == 0) r.vb = vert_t'($urandom);
    if (k < 2) r.op = OP_CLEAR;
    else if (k < 30) r.op = OP_ADD;
    else if (k < 97) r.op = OP_QUERY;
    else r.op = 2'd3;
    return r;
  endfunction

  // Response side: random stalls, one long hold to fill the block up.
  initial begin
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (fill_hold) begin
        m_axis_tready <= 1'b0;
        repeat (12000) @(posedge clk);
        fill_hold = 1'b0;
      end
      if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (width_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result width=%h", m_axis_tdata[29:0]);
      end else begin
        if (m_axis_tdata[29:0] !== width_queue[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("width mismatch: expected %h actual %h", width_queue[0],
                     m_axis_tdata[29:0]);
        end
        void'(width_queue.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    req_t r;
    int n;
    mismatches = 0;
    cycles = 0;
    fill_hold = 1'b0;
    quiet = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    clear_widest();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    add_row(mk(OP_QUERY, 0, 0, '0), 1, SAME_VERTEX);
    add_row(mk(OP_QUERY, 63, 63, '0), 1, SAME_VERTEX);
    add_row(mk(OP_QUERY, 0, 63, '0), 1, '0);
    add_row(mk(OP_ADD, 0, 63, 30'h3FFFFFFF), 0, '0);
    add_row(mk(OP_QUERY, 63, 0, '0), 1, MAX_WEIGHT);
    add_row(mk(OP_ADD, 1, 2, 30'h2AAAAAAA), 0, '0);
    add_row(mk(OP_ADD, 2, 3, 30'h15555555), 0, '0);
    add_row(mk(OP_QUERY, 1, 3, '0), 0, '0);
    add_row(mk(OP_ADD, 4, 5, '0), 0, '0);
    add_row(mk(OP_QUERY, 4, 5, '0), 1, '0);
    add_row(mk(OP_ADD, 6, 6, 30'd77), 0, '0);
    add_row(mk(OP_QUERY, 6, 6, '0), 1, SAME_VERTEX);
    add_row(mk(OP_ADD, 3, 0, 30'd1), 0, '0);
    add_row(mk(OP_QUERY, 1, 63, '0), 0, '0);
    add_row(mk(OP_ADD, 3, 63, 30'd5), 0, '0);
    add_row(mk(OP_QUERY, 3, 63, '0), 0, '0);
    add_row(mk(2'd3, 7, 8, 30'd9), 0, '0);
    add_row(mk(OP_CLEAR, 0, 0, '0), 0, '0);
    add_row(mk(OP_QUERY, 0, 63, '0), 1, '0);
    add_row(mk(OP_QUERY, 2, 2, 30'h3FFFFFFF), 1, SAME_VERTEX);

    foreach (directed[i]) begin
      if (directed[i].known) begin
        send_request(directed[i].r, 1);
        if (width_queue[width_queue.size()-1] !== directed[i].res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("directed row %0d: expected %h predicted %h", i, directed[i].res,
                     width_queue[width_queue.size()-1]);
        end
      end else begin
        send_request(directed[i].r, 1);
      end
    end
    drain_all();

    // Hold the response side while queries keep coming, then pause until drained.
    fill_hold = 1'b1;
    for (int i = 0; i < 8; i++) send_request(mk(OP_QUERY, i, 63 - i, '0), 0);
    drain_all();
    repeat (NV * NV + 2 * NV + 10) @(posedge clk);

    n = 0;
    while (n < 112) begin
      if (n % 25 == 0) begin
        send_request(mk(OP_CLEAR, 0, 0, '0), 1);
        n++;
      end
      if (n > 88) quiet = 1'b1;
      r = random_request((n % 50 < 40) ? 12 : NV);
      send_request(r, 1);
      n++;
    end
    drain_all();
    repeat (NV * NV + 2 * NV + 10) @(posedge clk);

    if (mismatches == 0 && width_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
